// File: sv/tbd_pkg.sv
`timescale 1ns / 1ps

package tbd_pkg;

  localparam int ItemsPerChunk  = 8;
  localparam int ChunksPerBlock = 4;
  localparam int QueueDepth     = 4;
  localparam int IntOperandExp  = 150;

  localparam logic [31:0] CanonNan = 32'h7fc0_0000;

  // One finished chunk handed from the front end to the float back end.
  typedef struct packed {
    logic signed [14:0] chunk_sum;
    logic [15:0]        act_scale;
    logic [15:0]        weight_scale;
    logic               end_block;
    logic               end_total;
  } tbd_job_t;

  // Unpacked float operand: value is man / 2^23 * 2^(exp - 127).
  typedef struct packed {
    logic        sign;
    logic [9:0]  exp;
    logic [23:0] man;
    logic        inf;
    logic        nan;
  } tbd_unp_t;

  // Unrounded result: value is man / 2^46 * 2^(exp - 127).
  typedef struct packed {
    logic               sign;
    logic signed [11:0] exp;
    logic [47:0]        man;
    logic               special;
    logic [31:0]        sval;
  } tbd_mid_t;

  function automatic tbd_unp_t unpack_f32(logic [31:0] x);
    tbd_unp_t u;
    u.sign = x[31];
    u.nan  = (x[30:23] == 8'hff) && (x[22:0] != 23'd0);
    u.inf  = (x[30:23] == 8'hff) && (x[22:0] == 23'd0);
    if (x[30:23] == 8'd0) begin
      u.man = {1'b0, x[22:0]};
      u.exp = 10'd1;
    end else begin
      u.man = {1'b1, x[22:0]};
      u.exp = {2'b00, x[30:23]};
    end
    return u;
  endfunction

  function automatic tbd_unp_t unpack_f16(logic [15:0] h);
    tbd_unp_t u;
    u.sign = h[15];
    u.nan  = (h[14:10] == 5'h1f) && (h[9:0] != 10'd0);
    u.inf  = (h[14:10] == 5'h1f) && (h[9:0] == 10'd0);
    if (h[14:10] == 5'd0) begin
      u.man = {14'd0, h[9:0]};
      u.exp = 10'd126;
    end else begin
      u.man = {1'b1, h[9:0], 13'd0};
      u.exp = 10'({5'd0, h[14:10]} + 10'd112);
    end
    return u;
  endfunction

  function automatic logic unp_is_zero(tbd_unp_t u);
    return !u.inf && !u.nan && (u.man == 24'd0);
  endfunction

  function automatic tbd_mid_t mul_stage(tbd_unp_t a, tbd_unp_t b);
    tbd_mid_t r;
    r.sign    = a.sign ^ b.sign;
    r.man     = 48'(a.man) * 48'(b.man);
    r.exp     = $signed({2'b00, a.exp}) + $signed({2'b00, b.exp}) - 12'sd127;
    r.special = a.nan || b.nan || a.inf || b.inf;
    if (a.nan || b.nan || (a.inf && unp_is_zero(b)) || (b.inf && unp_is_zero(a))) begin
      r.sval = CanonNan;
    end else begin
      r.sval = {r.sign, 8'hff, 23'd0};
    end
    return r;
  endfunction

  function automatic tbd_mid_t add_stage(tbd_unp_t x, tbd_unp_t y);
    tbd_mid_t    r;
    tbd_unp_t    big;
    tbd_unp_t    sml;
    logic        x_big;
    logic [9:0]  shift_amt;
    logic [47:0] mb;
    logic [47:0] ms;
    logic [47:0] ms_sh;
    logic [47:0] mask;
    x_big = (x.exp > y.exp) || ((x.exp == y.exp) && (x.man >= y.man));
    big   = x_big ? x : y;
    sml   = x_big ? y : x;
    shift_amt = big.exp - sml.exp;
    mb    = {1'b0, big.man, 23'd0};
    ms    = {1'b0, sml.man, 23'd0};
    ms_sh = ms >> shift_amt;
    mask  = (48'd1 << shift_amt) - 48'd1;
    ms_sh[0] = ms_sh[0] | (|(ms & mask));
    r.man = (x.sign == y.sign) ? (mb + ms_sh) : (mb - ms_sh);
    r.exp = $signed({2'b00, big.exp});
    r.sign = (r.man == 48'd0) ? (x.sign & y.sign) : big.sign;
    r.special = x.nan || y.nan || x.inf || y.inf;
    if (x.nan || y.nan || (x.inf && y.inf && (x.sign != y.sign))) begin
      r.sval = CanonNan;
    end else if (x.inf) begin
      r.sval = {x.sign, 8'hff, 23'd0};
    end else begin
      r.sval = {y.sign, 8'hff, 23'd0};
    end
    return r;
  endfunction

  // Normalize and round to nearest even, with subnormal and overflow results.
  function automatic logic [31:0] round_pack(tbd_mid_t v);
    logic [5:0]         lz;
    logic [47:0]        m;
    logic [47:0]        sh_m;
    logic [47:0]        mask;
    logic signed [11:0] en;
    logic [11:0]        sh;
    logic [30:0]        packed_v;
    logic               g;
    logic               st;
    logic               up;
    logic [31:0]        res;
    lz = 6'd0;
    for (int i = 0; i < 48; i++) begin
      if (v.man[i]) lz = 6'(47 - i);
    end
    m  = v.man << lz;
    en = v.exp + 12'sd1 - $signed({6'd0, lz});
    if (en >= 12'sd1) begin
      packed_v = {en[7:0], m[46:24]};
      g  = m[23];
      st = |m[22:0];
    end else begin
      sh   = 12'(12'sd1 - en);
      sh_m = m >> sh;
      mask = (48'd1 << sh) - 48'd1;
      packed_v = {8'd0, sh_m[46:24]};
      g  = sh_m[23];
      st = (|sh_m[22:0]) | (|(m & mask));
    end
    up = g & (st | packed_v[0]);
    if (v.man == 48'd0) begin
      res = {v.sign, 31'd0};
    end else if (en >= 12'sd255) begin
      res = {v.sign, 8'hff, 23'd0};
    end else begin
      res = {v.sign, 31'(packed_v + 31'(up))};
    end
    return res;
  endfunction

endpackage

// File: sv/ternary_int8_block_dot.sv
`timescale 1ns / 1ps

// Streaming dot product of 2-bit ternary-coded weights against int8 activations.
// Each item carries one code byte (four codes, LSB first, weight = code - 1) and
// four activations; the front end takes one item per clock and sums the products
// exactly over eight items into a chunk. Each finished chunk goes into a queue of
// four entries that feeds a float back end, which takes each chunk from the queue
// and then does the binary32 multiply and add, each split into a compute step and a
// round step, with a second multiply and add at the end of a block. The input runs
// at one item per cycle sustained; it stalls only when the queue is full at a chunk
// boundary, or while a finished result waits in the output register with the queue
// full behind it. The result is rounded to nearest even at each step, with any NaN
// given as the canonical quiet NaN. The user must write the block count register
// only while idle; the block itself does not enforce this.

module ternary_int8_block_dot #(
  parameter int MAX_BLOCKS = 256
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [8:0]        cfg_num_blocks_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [7:0]        code_byte_i,
  input  logic signed [7:0] act_a_i,
  input  logic signed [7:0] act_b_i,
  input  logic signed [7:0] act_c_i,
  input  logic signed [7:0] act_d_i,
  input  logic [15:0]       act_scale_i,
  input  logic [15:0]       weight_scale_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [31:0]       dot_result_o
);

  localparam int JobW = $bits(tbd_pkg::tbd_job_t);

  logic [8:0]        num_blocks_q;
  logic              q_full, q_push, q_valid, q_pop;
  tbd_pkg::tbd_job_t push_job, head_job;
  logic [JobW-1:0]   head_bits;

  // The count register is always ready; zero and oversize values are clamped downstream.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_blocks_q <= 9'd1;
    end else if (cfg_valid_i) begin
      num_blocks_q <= cfg_num_blocks_i;
    end
  end

  tbd_front #(
    .MAX_BLOCKS(MAX_BLOCKS)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .num_blocks_i  (num_blocks_q),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .code_byte_i   (code_byte_i),
    .act_a_i       (act_a_i),
    .act_b_i       (act_b_i),
    .act_c_i       (act_c_i),
    .act_d_i       (act_d_i),
    .act_scale_i   (act_scale_i),
    .weight_scale_i(weight_scale_i),
    .q_full_i      (q_full),
    .q_push_o      (q_push),
    .q_job_o       (push_job)
  );

  tbd_fifo #(
    .WIDTH(JobW),
    .DEPTH(tbd_pkg::QueueDepth)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (q_push),
    .push_data_i(push_job),
    .full_o     (q_full),
    .pop_i      (q_pop),
    .valid_o    (q_valid),
    .pop_data_o (head_bits)
  );

  assign head_job = tbd_pkg::tbd_job_t'(head_bits);

  tbd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_job_i     (head_job),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .dot_result_o(dot_result_o)
  );

endmodule

// File: sv/tbd_fifo.sv
`timescale 1ns / 1ps

module tbd_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [WIDTH-1:0] pop_data_o
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wr_q, wr_d, rd_q, rd_d;
  logic [CW-1:0]    cnt_q, cnt_d;

  assign full_o     = (cnt_q == CW'(DEPTH));
  assign valid_o    = (cnt_q != '0);
  assign pop_data_o = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == PW'(DEPTH - 1)) ? '0 : PW'(wr_q + 1'b1);
    end
    if (pop_i) begin
      rd_d = (rd_q == PW'(DEPTH - 1)) ? '0 : PW'(rd_q + 1'b1);
    end
    if (push_i && !pop_i) begin
      cnt_d = CW'(cnt_q + 1'b1);
    end else if (!push_i && pop_i) begin
      cnt_d = CW'(cnt_q - 1'b1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

endmodule

// File: sv/tbd_front.sv
`timescale 1ns / 1ps

module tbd_front #(
  parameter int MAX_BLOCKS = 256
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [8:0]           num_blocks_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [7:0]           code_byte_i,
  input  logic signed [7:0]    act_a_i,
  input  logic signed [7:0]    act_b_i,
  input  logic signed [7:0]    act_c_i,
  input  logic signed [7:0]    act_d_i,
  input  logic [15:0]          act_scale_i,
  input  logic [15:0]          weight_scale_i,
  input  logic                 q_full_i,
  output logic                 q_push_o,
  output tbd_pkg::tbd_job_t    q_job_o
);

  localparam int BIW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int LW  = ((BIW > 9) ? BIW : 9) + 2;

  logic [2:0]         byte_pos_q, byte_pos_d;
  logic [1:0]         chunk_pos_q, chunk_pos_d;
  logic [BIW-1:0]     block_idx_q, block_idx_d;
  logic signed [14:0] chunk_acc_q, chunk_acc_d;

  logic signed [9:0]  lane_val [4];
  logic signed [7:0]  acts [4];
  logic signed [11:0] item_sum;
  logic signed [14:0] acc_new;
  logic [LW-1:0]      limit;
  logic               last_block;
  logic               chunk_end;
  logic               accept;

  assign acts[0] = act_a_i;
  assign acts[1] = act_b_i;
  assign acts[2] = act_c_i;
  assign acts[3] = act_d_i;

  // Each weight is code minus one, so the product is a negate, zero, copy or double.
  always_comb begin
    for (int l = 0; l < 4; l++) begin
      case (code_byte_i[2*l +: 2])
        2'd0:    lane_val[l] = -10'(acts[l]);
        2'd1:    lane_val[l] = '0;
        2'd2:    lane_val[l] = 10'(acts[l]);
        default: lane_val[l] = 10'(acts[l]) <<< 1;
      endcase
    end
    item_sum = 12'(lane_val[0]) + 12'(lane_val[1]) + 12'(lane_val[2]) + 12'(lane_val[3]);
  end

  assign acc_new   = chunk_acc_q + 15'(item_sum);
  assign chunk_end = (byte_pos_q == 3'(tbd_pkg::ItemsPerChunk - 1));

  always_comb begin
    if (num_blocks_i == 9'd0) begin
      limit = LW'(1);
    end else if (LW'(num_blocks_i) > LW'(MAX_BLOCKS)) begin
      limit = LW'(MAX_BLOCKS);
    end else begin
      limit = LW'(num_blocks_i);
    end
  end

  assign last_block = (LW'(block_idx_q) + LW'(1)) >= limit;
  assign in_ready_o = !chunk_end || !q_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign q_push_o   = accept && chunk_end;

  always_comb begin
    q_job_o.chunk_sum    = acc_new;
    q_job_o.act_scale    = act_scale_i;
    q_job_o.weight_scale = weight_scale_i;
    q_job_o.end_block    = (chunk_pos_q == 2'(tbd_pkg::ChunksPerBlock - 1));
    q_job_o.end_total    = q_job_o.end_block && last_block;
  end

  always_comb begin
    byte_pos_d  = byte_pos_q;
    chunk_pos_d = chunk_pos_q;
    block_idx_d = block_idx_q;
    chunk_acc_d = chunk_acc_q;
    if (accept) begin
      if (!chunk_end) begin
        byte_pos_d  = byte_pos_q + 3'd1;
        chunk_acc_d = acc_new;
      end else begin
        byte_pos_d  = '0;
        chunk_acc_d = '0;
        chunk_pos_d = chunk_pos_q + 2'd1;
        if (q_job_o.end_block) begin
          block_idx_d = last_block ? '0 : BIW'(block_idx_q + 1'b1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_pos_q  <= '0;
      chunk_pos_q <= '0;
      block_idx_q <= '0;
      chunk_acc_q <= '0;
    end else begin
      byte_pos_q  <= byte_pos_d;
      chunk_pos_q <= chunk_pos_d;
      block_idx_q <= block_idx_d;
      chunk_acc_q <= chunk_acc_d;
    end
  end

endmodule

// File: sv/tbd_back.sv
`timescale 1ns / 1ps

module tbd_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              q_valid_i,
  input  tbd_pkg::tbd_job_t q_job_i,
  output logic              q_pop_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [31:0]       dot_result_o
);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_MUL  = 6'b000010,
    S_MRND = 6'b000100,
    S_ADD  = 6'b001000,
    S_ARND = 6'b010000,
    S_OUT  = 6'b100000
  } state_e;

  state_e              state_q, state_d;
  tbd_pkg::tbd_job_t   job_q, job_d;
  logic                stage_q, stage_d;
  logic [31:0]         prod_q, prod_d;
  logic [31:0]         block_acc_q, block_acc_d;
  logic [31:0]         total_acc_q, total_acc_d;
  tbd_pkg::tbd_mid_t   mid_q, mid_d;
  logic [31:0]         res_q, res_d;
  logic                res_valid_q, res_valid_d;

  tbd_pkg::tbd_unp_t   op_a, op_b, op_int;
  logic [14:0]         sum_mag;
  logic [31:0]         rnd;
  logic [31:0]         canon;

  // The exact chunk sum enters the multiplier as an integer mantissa.
  always_comb begin
    sum_mag     = job_q.chunk_sum[14] ? 15'(-job_q.chunk_sum) : 15'(job_q.chunk_sum);
    op_int.sign = job_q.chunk_sum[14];
    op_int.exp  = 10'(tbd_pkg::IntOperandExp);
    op_int.man  = 24'(sum_mag);
    op_int.inf  = 1'b0;
    op_int.nan  = 1'b0;
    op_a = stage_q ? tbd_pkg::unpack_f16(job_q.weight_scale)
                   : tbd_pkg::unpack_f16(job_q.act_scale);
    op_b = stage_q ? tbd_pkg::unpack_f32(block_acc_q) : op_int;
  end

  assign rnd   = mid_q.special ? mid_q.sval : tbd_pkg::round_pack(mid_q);
  assign canon = ((total_acc_q[30:23] == 8'hff) && (total_acc_q[22:0] != 23'd0))
                 ? tbd_pkg::CanonNan : total_acc_q;

  assign q_pop_o      = (state_q == S_IDLE) && q_valid_i;
  assign out_valid_o  = res_valid_q;
  assign dot_result_o = res_q;

  always_comb begin
    state_d     = state_q;
    job_d       = job_q;
    stage_d     = stage_q;
    prod_d      = prod_q;
    block_acc_d = block_acc_q;
    total_acc_d = total_acc_q;
    mid_d       = mid_q;
    res_d       = res_q;
    res_valid_d = res_valid_q && !out_ready_i;
    case (state_q)
      S_IDLE: begin
        if (q_valid_i) begin
          job_d   = q_job_i;
          stage_d = 1'b0;
          state_d = S_MUL;
        end
      end
      S_MUL: begin
        mid_d   = tbd_pkg::mul_stage(op_a, op_b);
        state_d = S_MRND;
      end
      S_MRND: begin
        prod_d  = rnd;
        state_d = S_ADD;
      end
      S_ADD: begin
        mid_d = tbd_pkg::add_stage(tbd_pkg::unpack_f32(stage_q ? total_acc_q : block_acc_q),
                                   tbd_pkg::unpack_f32(prod_q));
        state_d = S_ARND;
      end
      S_ARND: begin
        if (!stage_q) begin
          block_acc_d = rnd;
          if (job_q.end_block) begin
            stage_d = 1'b1;
            state_d = S_MUL;
          end else begin
            state_d = S_IDLE;
          end
        end else begin
          total_acc_d = rnd;
          block_acc_d = '0;
          state_d     = job_q.end_total ? S_OUT : S_IDLE;
        end
      end
      S_OUT: begin
        if (!res_valid_q || out_ready_i) begin
          res_d       = canon;
          res_valid_d = 1'b1;
          total_acc_d = '0;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      stage_q     <= 1'b0;
      block_acc_q <= '0;
      total_acc_q <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      stage_q     <= stage_d;
      block_acc_q <= block_acc_d;
      total_acc_q <= total_acc_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    job_q  <= job_d;
    prod_q <= prod_d;
    mid_q  <= mid_d;
    res_q  <= res_d;
  end

endmodule

// File: verif/ternary_int8_block_dot_tb.sv
`timescale 1ns / 1ps

// Keeps a running prediction of the ternary dot product and checks each
// dot_result that the block hands out against it. The binary32 arithmetic
// is rebuilt from integer parts so that every multiply and add rounds
// exactly once to nearest even.
class dot_scoreboard;
  int unsigned block_count;
  int          item_pos;
  int          chunk_pos;
  int          block_pos;
  int          chunk_sum;
  bit [31:0]   block_sum;
  bit [31:0]   total_sum;
  bit [31:0]   dot_q[$];
  int          errors;

  function new();
    block_count = 1;
    item_pos    = 0;
    chunk_pos   = 0;
    block_pos   = 0;
    chunk_sum   = 0;
    block_sum   = 32'h0;
    total_sum   = 32'h0;
    errors      = 0;
  endfunction

  // Rounds sign * mag * 2^ex to the nearest binary32, ties to even.
  function bit [31:0] round_f32(bit sgn, bit [299:0] mag, int ex);
    int         p;
    int         q;
    int         s;
    bit [299:0] mt;
    bit         g;
    bit         st;
    if (mag == 0) return {sgn, 31'd0};
    p = 0;
    for (int i = 0; i < 300; i++) begin
      if (mag[i]) p = i;
    end
    q = p + ex - 23;
    if (q < -149) q = -149;
    s  = q - ex;
    g  = 1'b0;
    st = 1'b0;
    if (s <= 0) begin
      mt = mag << (-s);
    end else begin
      mt = mag >> s;
      g  = mag[s-1];
      st = (mag & ((300'd1 << (s - 1)) - 300'd1)) != 0;
    end
    if (g && (st || mt[0])) mt = mt + 300'd1;
    if (mt[24]) begin
      mt = mt >> 1;
      q++;
    end
    if (mt[23]) begin
      if (q + 150 >= 255) return {sgn, 8'hff, 23'd0};
      return {sgn, 8'(q + 150), mt[22:0]};
    end
    return {sgn, 8'd0, mt[22:0]};
  endfunction

  function bit is_nan(bit [31:0] x);
    return (x[30:23] == 8'hff) && (x[22:0] != 0);
  endfunction

  function bit is_inf(bit [31:0] x);
    return (x[30:23] == 8'hff) && (x[22:0] == 0);
  endfunction

  // Splits a finite binary32 into an integer significand and the weight of its lsb.
  function void split_f32(input bit [31:0] x, output bit [299:0] m, output int e);
    if (x[30:23] == 8'd0) begin
      m = 300'(x[22:0]);
      e = -149;
    end else begin
      m = 300'({1'b1, x[22:0]});
      e = int'(x[30:23]) - 150;
    end
  endfunction

  function bit [31:0] half_to_f32(bit [15:0] h);
    if (h[14:10] == 5'h1f) begin
      if (h[9:0] == 0) return {h[15], 8'hff, 23'd0};
      return 32'h7fc0_0000;
    end
    if (h[14:10] == 5'd0) return round_f32(h[15], 300'(h[9:0]), -24);
    return round_f32(h[15], 300'({1'b1, h[9:0]}), int'(h[14:10]) - 25);
  endfunction

  function bit [31:0] mul_f32(bit [31:0] a, bit [31:0] b);
    bit [299:0] ma;
    bit [299:0] mb;
    int         ea;
    int         eb;
    if (is_nan(a) || is_nan(b)) return 32'h7fc0_0000;
    if ((is_inf(a) && b[30:0] == 0) || (is_inf(b) && a[30:0] == 0)) return 32'h7fc0_0000;
    if (is_inf(a) || is_inf(b)) return {a[31] ^ b[31], 8'hff, 23'd0};
    split_f32(a, ma, ea);
    split_f32(b, mb, eb);
    return round_f32(a[31] ^ b[31], ma * mb, ea + eb);
  endfunction

  function bit [31:0] add_f32(bit [31:0] a, bit [31:0] b);
    bit [299:0] ma;
    bit [299:0] mb;
    int         ea;
    int         eb;
    int         emin;
    if (is_nan(a) || is_nan(b)) return 32'h7fc0_0000;
    if (is_inf(a) && is_inf(b) && (a[31] != b[31])) return 32'h7fc0_0000;
    if (is_inf(a)) return a;
    if (is_inf(b)) return b;
    split_f32(a, ma, ea);
    split_f32(b, mb, eb);
    emin = (ea < eb) ? ea : eb;
    ma = ma << (ea - emin);
    mb = mb << (eb - emin);
    if (a[31] == b[31]) return round_f32(a[31], ma + mb, emin);
    if (ma > mb) return round_f32(a[31], ma - mb, emin);
    if (mb > ma) return round_f32(b[31], mb - ma, emin);
    return 32'h0;
  endfunction

  function void set_blocks(bit [8:0] v);
    block_count = v;
  endfunction

  function int pending();
    return dot_q.size();
  endfunction

  // Advances the prediction by one accepted item.
  function void note_item(bit [7:0] code, bit [7:0] a, bit [7:0] b, bit [7:0] c,
                          bit [7:0] d, bit [15:0] act_scale, bit [15:0] weight_scale);
    bit [7:0]    acts[4];
    int          limit;
    bit [31:0]   chunk_f;
    bit [31:0]   res;
    acts[0] = a;
    acts[1] = b;
    acts[2] = c;
    acts[3] = d;
    for (int l = 0; l < 4; l++) begin
      chunk_sum += (int'(code[2*l +: 2]) - 1) * int'($signed(acts[l]));
    end
    if (item_pos < 7) begin
      item_pos++;
      return;
    end
    item_pos = 0;
    chunk_f  = round_f32(chunk_sum < 0, 300'(chunk_sum < 0 ? -chunk_sum : chunk_sum), 0);
    block_sum = add_f32(block_sum, mul_f32(half_to_f32(act_scale), chunk_f));
    chunk_sum = 0;
    if (chunk_pos < 3) begin
      chunk_pos++;
      return;
    end
    chunk_pos = 0;
    total_sum = add_f32(total_sum, mul_f32(half_to_f32(weight_scale), block_sum));
    block_sum = 32'h0;
    // A count of zero acts as one; counts beyond the block's maximum saturate.
    limit = (block_count == 0) ? 1 : (block_count > 256) ? 256 : block_count;
    if (block_pos + 1 < limit) begin
      block_pos++;
      return;
    end
    block_pos = 0;
    res = is_nan(total_sum) ? 32'h7fc0_0000 : total_sum;
    dot_q.push_back(res);
    total_sum = 32'h0;
  endfunction

  function void check_result(bit [31:0] got);
    bit [31:0] want;
    if (dot_q.size() == 0) begin
      $error("dot_result: no result expected, actual %h", got);
      errors++;
      return;
    end
    want = dot_q.pop_front();
    if (got !== want) begin
      $error("dot_result mismatch: expected %h, actual %h", want, got);
      errors++;
    end
  endfunction
endclass

module ternary_int8_block_dot_tb;

  logic              clk_i;
  logic              rst_ni;
  logic              cfg_valid_i;
  logic              cfg_ready_o;
  logic [8:0]        cfg_num_blocks_i;
  logic              in_valid_i;
  logic              in_ready_o;
  logic [7:0]        code_byte_i;
  logic signed [7:0] act_a_i;
  logic signed [7:0] act_b_i;
  logic signed [7:0] act_c_i;
  logic signed [7:0] act_d_i;
  logic [15:0]       act_scale_i;
  logic [15:0]       weight_scale_i;
  logic              out_valid_o;
  logic              out_ready_i;
  logic [31:0]       dot_result_o;

  dot_scoreboard sb = new();

  // Random idle bursts are switched off for the last phase of the run.
  bit idle_en = 1'b1;
  // Set by the stimulus to ask the result side for one long hold-off.
  bit long_stall_req = 1'b0;
  int quiet_cycles = 0;

  ternary_int8_block_dot DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_num_blocks_i(cfg_num_blocks_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .code_byte_i     (code_byte_i),
    .act_a_i         (act_a_i),
    .act_b_i         (act_b_i),
    .act_c_i         (act_c_i),
    .act_d_i         (act_d_i),
    .act_scale_i     (act_scale_i),
    .weight_scale_i  (weight_scale_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .dot_result_o    (dot_result_o)
  );

  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Writes the block count and mirrors it in the prediction once it is taken.
  task automatic write_blocks(input logic [8:0] value);
    cfg_valid_i      <= 1'b1;
    cfg_num_blocks_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.set_blocks(value);
    cfg_valid_i <= 1'b0;
  endtask

  // Offers one item and holds it until accepted. A random gap may follow.
  task automatic send_item(input logic [7:0] code, input logic [7:0] a, input logic [7:0] b,
                           input logic [7:0] c, input logic [7:0] d,
                           input logic [15:0] a_scale, input logic [15:0] w_scale);
    in_valid_i     <= 1'b1;
    code_byte_i    <= code;
    act_a_i        <= a;
    act_b_i        <= b;
    act_c_i        <= c;
    act_d_i        <= d;
    act_scale_i    <= a_scale;
    weight_scale_i <= w_scale;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_item(code, a, b, c, d, a_scale, w_scale);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk_i);
    end
  endtask

  // Mostly ordinary fp16 scales, now and then any pattern at all, so that
  // infinities, NaNs and subnormals turn up without poisoning every result.
  function automatic logic [15:0] pick_scale();
    if ($urandom_range(0, 9) == 0) return 16'($urandom);
    return {1'($urandom), 5'($urandom_range(8, 20)), 10'($urandom)};
  endfunction

  // Sends whole dot products of random items for the current block count.
  task automatic send_dots(input int dots, input int blocks);
    for (int i = 0; i < dots * blocks * 32; i++) begin
      send_item(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                pick_scale(), pick_scale());
    end
  endtask

  // Lets the block go quiet: every expected result has arrived, and the
  // back end has had time to drain any chunk that causes no result.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  // Directed blocks: extreme codes and activations, subnormal, largest,
  // negative, infinite and NaN scales, and an all-zero-weight block whose
  // zero sums meet an infinite scale.
  task automatic run_directed();
    logic [7:0]  codes[6];
    logic [15:0] a_sc[4][4];
    logic [15:0] w_sc[4];
    logic [7:0]  code;
    codes = '{8'h00, 8'hff, 8'h55, 8'haa, 8'he4, 8'h1b};
    a_sc  = '{'{16'h0001, 16'h7bff, 16'h03ff, 16'h8400},
              '{16'h7c00, 16'h3c00, 16'hbc00, 16'h3c00},
              '{16'h3c00, 16'h7e00, 16'h3c00, 16'hfc00},
              '{16'h7c00, 16'h3c00, 16'h0000, 16'h8000}};
    w_sc  = '{16'hfbff, 16'h3c00, 16'h3c00, 16'h8000};
    for (int blk = 0; blk < 4; blk++) begin
      for (int i = 0; i < 32; i++) begin
        code = (blk == 3) ? 8'h55 : codes[i % 6];
        send_item(code, i[0] ? 8'h7f : 8'h80, i[0] ? 8'h80 : 8'h7f,
                  i[1] ? 8'h7f : 8'h80, i[2] ? 8'h80 : 8'h7f,
                  (i % 8 == 7) ? a_sc[blk][i / 8] : 16'($urandom),
                  (i == 31) ? w_sc[blk] : 16'($urandom));
      end
    end
  endtask

  // Result side: checks each accepted result and stalls in random bursts,
  // or for one long stretch on request so that the block backs up.
  initial begin
    int hold;
    hold = 0;
    out_ready_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) sb.check_result(dot_result_o);
      if (long_stall_req) begin
        out_ready_i <= 1'b0;
        repeat (300) @(posedge clk_i);
        long_stall_req = 1'b0;
        out_ready_i <= 1'b1;
      end else if (hold > 0) begin
        hold--;
        out_ready_i <= 1'b0;
      end else if (idle_en && $urandom_range(0, 4) == 0) begin
        hold = $urandom_range(1, 7) - 1;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // Ends the run if nothing moves on any channel for far too long.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= 5000) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    rst_ni           = 1'b0;
    cfg_valid_i      = 1'b0;
    cfg_num_blocks_i = 9'd0;
    in_valid_i       = 1'b0;
    code_byte_i      = 8'd0;
    act_a_i          = 8'sd0;
    act_b_i          = 8'sd0;
    act_c_i          = 8'sd0;
    act_d_i          = 8'sd0;
    act_scale_i      = 16'd0;
    weight_scale_i   = 16'd0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // A zero count behaves as a single block.
    write_blocks(9'd0);
    run_directed();
    wait_drained();

    // Single-block products, with one long result-side hold-off so the
    // chunk queue fills and the input stalls behind it.
    write_blocks(9'd1);
    long_stall_req = 1'b1;
    send_dots(10, 1);
    wait_drained();

    write_blocks(9'd3);
    send_dots(3, 3);
    wait_drained();

    write_blocks(9'd2);
    send_dots(2, 2);
    wait_drained();

    write_blocks(9'd4);
    send_dots(1, 4);
    wait_drained();

    // Closing stretch at full rate on both sides.
    idle_en = 1'b0;
    write_blocks(9'd1);
    send_dots(5, 1);
    wait_drained();
    repeat (30) @(posedge clk_i);

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
